[sv/eht_pkg.sv]
// ----------------------------------------------------------------------------
// eht_pkg: shared definitions for the entropy health test unit
// Register indexes, field widths, reset values and the step control bundle.
// ----------------------------------------------------------------------------
package eht_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 8;

  localparam int BYTE_W    = 8;
  localparam int REP_CNT_W = 8;
  localparam int APT_W     = 11;
  localparam int START_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 13;

  localparam logic [CFG_IDX_W-1:0] REG_RCT_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APT_CUTOFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APT_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP    = 3'd3;

  localparam logic [REP_CNT_W-1:0] RCT_CUTOFF_RST = 8'd4;
  localparam logic [APT_W-1:0]     APT_CUTOFF_RST = 11'd13;
  localparam logic [APT_W-1:0]     APT_WINDOW_RST = 11'd512;
  localparam logic [START_W-1:0]   STARTUP_RST    = 13'd1024;

  localparam logic [REP_CNT_W-1:0] REP_CNT_MAX = 8'd255;

  typedef struct packed {
    logic             en;
    logic [BYTE_W-1:0] byte_val;
  } eht_step_t;

endpackage

[sv/entropy_health_test_rct_apt_unit.sv]
// ----------------------------------------------------------------------------
// entropy_health_test_rct_apt_unit: RCT and APT entropy health monitor
// Passes each noise byte through with start-up, per-test and latched status.
//
//   channel  ports                                   role
//   in       in_valid/in_ready, in_sample            raw noise byte
//   out      out_valid/out_ready, out_sample_out,    byte plus health status
//            out_usable/rct_fail/apt_fail/
//            health_failed/startup_done
//   cfg      cfg_we, cfg_index, cfg_data             cutoffs, window, start-up
//
// One item per cycle sustained while out_ready is high; an accepted item passes
// through the input register, then the result register, before out_valid rises.
// The test update runs as the item moves from the input register to the
// result register. Reset (synchronous) restores register defaults and clears
// all test state. A stalled result holds its register while one more item
// waits in the input register.
// ----------------------------------------------------------------------------
module entropy_health_test_rct_apt_unit #(
  parameter int SAMPLE_BITS = eht_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [eht_pkg::BYTE_W-1:0]    in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [eht_pkg::BYTE_W-1:0]    out_sample_out,
  output logic                         out_usable,
  output logic                         out_rct_fail,
  output logic                         out_apt_fail,
  output logic                         out_health_failed,
  output logic                         out_startup_done,
  input  logic                         cfg_we,
  input  logic [eht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eht_pkg::CFG_W-1:0]     cfg_data
);
  import eht_pkg::*;

  logic [REP_CNT_W-1:0] rct_cutoff_r;
  logic [APT_W-1:0]     apt_cutoff_r;
  logic [APT_W-1:0]     apt_window_r;
  logic [START_W-1:0]   startup_samples_r;

  logic                 s1_valid_r;
  logic [BYTE_W-1:0]    s1_byte_r;
  logic                 advance;

  logic [START_W-1:0]   startup_seen_r, startup_seen_nxt;
  logic                 failed_r, failed_nxt;
  logic                 done;
  logic                 rct_fail;
  logic                 apt_fail;
  eht_step_t            step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rct_cutoff_r      <= RCT_CUTOFF_RST;
      apt_cutoff_r      <= APT_CUTOFF_RST;
      apt_window_r      <= APT_WINDOW_RST;
      startup_samples_r <= STARTUP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RCT_CUTOFF: rct_cutoff_r      <= cfg_data[REP_CNT_W-1:0];
        REG_APT_CUTOFF: apt_cutoff_r      <= cfg_data[APT_W-1:0];
        REG_APT_WINDOW: apt_window_r      <= cfg_data[APT_W-1:0];
        REG_STARTUP:    startup_samples_r <= cfg_data[START_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_sample;
    end
  end

  assign step.en       = advance && !failed_r;
  assign step.byte_val = s1_byte_r;

  eht_rct #(.SAMPLE_BITS(SAMPLE_BITS)) u_rct (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .cutoff (rct_cutoff_r),
    .fail   (rct_fail)
  );

  eht_apt #(.SAMPLE_BITS(SAMPLE_BITS)) u_apt (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .cutoff (apt_cutoff_r),
    .window (apt_window_r),
    .fail   (apt_fail)
  );

  assign done = (startup_seen_r >= startup_samples_r);

  always_comb begin
    startup_seen_nxt = startup_seen_r;
    failed_nxt       = failed_r;
    if (!failed_r) begin
      if (!done) begin
        startup_seen_nxt = startup_seen_r + 1'b1;
      end
      failed_nxt = rct_fail || apt_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_seen_r <= '0;
      failed_r       <= 1'b0;
    end else if (advance) begin
      startup_seen_r <= startup_seen_nxt;
      failed_r       <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample_out    <= s1_byte_r;
      out_usable        <= done && !failed_nxt;
      out_rct_fail      <= !failed_r && rct_fail;
      out_apt_fail      <= !failed_r && apt_fail;
      out_health_failed <= failed_nxt;
      out_startup_done  <= done;
    end
  end

endmodule

[sv/eht_rct.sv]
// ----------------------------------------------------------------------------
// eht_rct: repetition count test
// Tracks the current run of equal samples and flags a run at the cutoff.
// ----------------------------------------------------------------------------
module eht_rct #(
  parameter int SAMPLE_BITS = eht_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  eht_pkg::eht_step_t           step,
  input  logic [eht_pkg::REP_CNT_W-1:0] cutoff,
  output logic                         fail
);
  import eht_pkg::*;

  localparam int CMP_BITS = (SAMPLE_BITS < BYTE_W) ? SAMPLE_BITS : BYTE_W;

  logic [CMP_BITS-1:0]  rep_value_r, rep_value_nxt;
  logic [REP_CNT_W-1:0] rep_count_r, rep_count_nxt;
  logic [CMP_BITS-1:0]  s;
  logic                 match;
  logic [REP_CNT_W-1:0] cnt_inc;

  assign s       = step.byte_val[CMP_BITS-1:0];
  assign match   = (rep_count_r != '0) && (s == rep_value_r);
  assign cnt_inc = (rep_count_r < REP_CNT_MAX) ? rep_count_r + 1'b1 : rep_count_r;
  assign fail    = match && (cnt_inc >= cutoff);

  always_comb begin
    rep_value_nxt = match ? rep_value_r : s;
    rep_count_nxt = match ? cnt_inc : REP_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_value_r <= '0;
      rep_count_r <= '0;
    end else if (step.en) begin
      rep_value_r <= rep_value_nxt;
      rep_count_r <= rep_count_nxt;
    end
  end

endmodule

[sv/eht_apt.sv]
// ----------------------------------------------------------------------------
// eht_apt: adaptive proportion test
// Counts recurrences of the window's first sample and flags the cutoff.
// ----------------------------------------------------------------------------
module eht_apt #(
  parameter int SAMPLE_BITS = eht_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  eht_pkg::eht_step_t       step,
  input  logic [eht_pkg::APT_W-1:0] cutoff,
  input  logic [eht_pkg::APT_W-1:0] window,
  output logic                     fail
);
  import eht_pkg::*;

  localparam int CMP_BITS = (SAMPLE_BITS < BYTE_W) ? SAMPLE_BITS : BYTE_W;

  logic [CMP_BITS-1:0] win_value_r, win_value_nxt;
  logic [APT_W-1:0]    matches_r, matches_nxt;
  logic [APT_W-1:0]    position_r, position_nxt;
  logic [CMP_BITS-1:0] s;
  logic                open;
  logic                hit;
  logic [APT_W-1:0]    m_inc;
  logic [APT_W-1:0]    p_inc;

  assign s     = step.byte_val[CMP_BITS-1:0];
  assign open  = (matches_r != '0);
  assign hit   = open && (s == win_value_r);
  assign m_inc = matches_r + 1'b1;
  assign p_inc = position_r + 1'b1;
  assign fail  = hit && (m_inc >= cutoff);

  always_comb begin
    win_value_nxt = win_value_r;
    matches_nxt   = matches_r;
    position_nxt  = position_r;
    if (!open) begin
      win_value_nxt = s;
      matches_nxt   = APT_W'(1);
      position_nxt  = APT_W'(1);
    end else if (fail) begin
      matches_nxt = '0;
    end else begin
      position_nxt = p_inc;
      matches_nxt  = (p_inc >= window) ? '0 : (hit ? m_inc : matches_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_value_r <= '0;
      matches_r   <= '0;
      position_r  <= '0;
    end else if (step.en) begin
      win_value_r <= win_value_nxt;
      matches_r   <= matches_nxt;
      position_r  <= position_nxt;
    end
  end

endmodule

[sv/eht_checker.sv]
// ----------------------------------------------------------------------------
// eht_checker: port-level checks for the entropy health test unit
// Watches the result channel for held stalled items, status consistency and the sticky failure.
// ----------------------------------------------------------------------------
module eht_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [eht_pkg::BYTE_W-1:0] out_sample_out,
  input logic                      out_usable,
  input logic                      out_rct_fail,
  input logic                      out_apt_fail,
  input logic                      out_health_failed,
  input logic                      out_startup_done
);
  import eht_pkg::*;

  logic seen_fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_fail_r <= 1'b0;
    end else if (out_valid && out_ready && out_health_failed) begin
      seen_fail_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result item changed while stalled");

  a_usable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_usable |->
      out_startup_done && !out_health_failed && !out_rct_fail && !out_apt_fail)
    else $error("usable item with failing status");

  a_fail_latches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rct_fail || out_apt_fail) |-> out_health_failed)
    else $error("test failure without latched failure");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_fail_r |-> out_health_failed && !out_usable)
    else $error("latched failure cleared");

endmodule

bind entropy_health_test_rct_apt_unit eht_checker u_eht_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sample_out    (out_sample_out),
  .out_usable        (out_usable),
  .out_rct_fail      (out_rct_fail),
  .out_apt_fail      (out_apt_fail),
  .out_health_failed (out_health_failed),
  .out_startup_done  (out_startup_done)
);
